### hw/rtl/barg_pkg.sv
// ----------------------------------------------------------------------------
// barg_pkg: shared types and constants of the bank attitude reference generator
// Fixed-point widths, CORDIC constants, payload structs, the sequencer states
// and the micro-op table that drives the shared arithmetic unit.
// ----------------------------------------------------------------------------
package barg_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;

   localparam int WORD_W   = 32;
   localparam int ANG_W    = 19;
   localparam int PERIOD_W = 20;
   localparam int INVP_W   = 31;
   localparam int POLE_W   = 18;
   localparam int CSR_IDX_W = 3;

   // Sine and cosine in Q(FRAC_BITS), magnitude just above one.
   localparam int TRIG_W = FRAC_BITS + 2;
   // CORDIC datapath in Q30.
   localparam int Z_W  = 36;
   localparam int XY_W = 33;
   localparam int STEP_CNT_W = $clog2(CORDIC_STEPS);
   localparam int TRIG_SHIFT = 30 - FRAC_BITS;
   // Divider numerator: cosine scaled by one, or one squared.
   localparam int NUM_W = 2 * FRAC_BITS + 2;
   localparam int DEN_W = TRIG_W;

   localparam logic signed [Z_W-1:0]  Q30_PI      = Z_W'(64'sd3373259426);
   localparam logic signed [Z_W-1:0]  Q30_HALF_PI = Z_W'(64'sd1686629713);
   localparam logic signed [Z_W-1:0]  Q30_TWO_PI  = Z_W'(64'sd6746518852);
   localparam logic signed [XY_W-1:0] Q30_GAIN    = XY_W'(64'sd652032874);

   localparam logic signed [WORD_W-1:0] ONE_Q    = WORD_W'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [WORD_W-1:0] WORD_MAX = WORD_W'(64'sd2147483647);
   localparam logic signed [WORD_W-1:0] WORD_MIN = WORD_W'(-64'sd2147483648);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_PER   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_POLE = 3'd4;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1 << FRAC_BITS);
   localparam logic [INVP_W-1:0]   INV_PER_RESET = INVP_W'(1 << FRAC_BITS);

   typedef struct packed {
      logic signed [ANG_W-1:0]  angle_of_attack;
      logic signed [WORD_W-1:0] bank_target;
      logic signed [WORD_W-1:0] bank_rate_target;
      logic signed [WORD_W-1:0] bank_feedforward;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] roll_command;
      logic signed [WORD_W-1:0] yaw_command;
      logic signed [WORD_W-1:0] bank_ref_next;
      logic signed [WORD_W-1:0] yaw_rate_ref_next;
      logic signed [WORD_W-1:0] roll_rate_ref_next;
      logic                     fault_flag;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TRIG, ST_DIV_COT, ST_DIV_CSC, ST_CALC, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {OP_MUL, OP_MULH, OP_ADD, OP_SUB} op_type;

   typedef enum logic [4:0] {
      L_C0, L_C1, L_T, L_TI, L_ONE, L_P, L_S, L_C, L_W, L_MT, L_U,
      L_BANK, L_YAW, L_ROLL, L_COT, L_CSC,
      L_KMU, L_KW, L_T1, L_T2, L_DN, L_DL, L_UN, L_UL
   } loc_type;

   typedef struct packed {
      op_type  op;
      loc_type src_a;
      loc_type src_b;
      loc_type dst;
   } uop_type;

   localparam int UOP_COUNT = 32;
   localparam int PC_W = $clog2(UOP_COUNT);

   function automatic logic [Z_W-1:0] atan_q30(input logic [4:0] idx);
      logic [Z_W-1:0] v;
      case (idx)
         5'd0:  v = Z_W'(843314856);
         5'd1:  v = Z_W'(497837829);
         5'd2:  v = Z_W'(263043836);
         5'd3:  v = Z_W'(133525158);
         5'd4:  v = Z_W'(67021686);
         5'd5:  v = Z_W'(33543515);
         5'd6:  v = Z_W'(16775850);
         5'd7:  v = Z_W'(8388437);
         5'd8:  v = Z_W'(4194282);
         5'd9:  v = Z_W'(2097149);
         5'd10: v = Z_W'(1048575);
         5'd11: v = Z_W'(524287);
         5'd12: v = Z_W'(262143);
         5'd13: v = Z_W'(131071);
         5'd14: v = Z_W'(65535);
         5'd15: v = Z_W'(32767);
         5'd16: v = Z_W'(16383);
         5'd17: v = Z_W'(8191);
         5'd18: v = Z_W'(4095);
         5'd19: v = Z_W'(2047);
         5'd20: v = Z_W'(1023);
         5'd21: v = Z_W'(511);
         5'd22: v = Z_W'(255);
         5'd23: v = Z_W'(127);
         default: v = '0;
      endcase
      return v;
   endfunction

   // One step of the update: closed-loop commands, then the new references.
   function automatic uop_type uop_at(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         5'd0:  u = '{OP_MUL,  L_C0,   L_S,   L_KMU};
         5'd1:  u = '{OP_MUL,  L_KMU,  L_TI,  L_KMU};
         5'd2:  u = '{OP_MUL,  L_KMU,  L_TI,  L_KMU};
         5'd3:  u = '{OP_MUL,  L_C1,   L_TI,  L_KW};
         5'd4:  u = '{OP_MUL,  L_S,    L_W,   L_T1};
         5'd5:  u = '{OP_MUL,  L_T1,   L_TI,  L_T1};
         5'd6:  u = '{OP_SUB,  L_T1,   L_YAW, L_T1};
         5'd7:  u = '{OP_MUL,  L_KW,   L_T1,  L_T1};
         5'd8:  u = '{OP_SUB,  L_MT,   L_BANK, L_T2};
         5'd9:  u = '{OP_MUL,  L_KMU,  L_T2,  L_T2};
         5'd10: u = '{OP_ADD,  L_T1,   L_T2,  L_DN};
         5'd11: u = '{OP_SUB,  L_ONE,  L_P,   L_T1};
         5'd12: u = '{OP_MUL,  L_T1,   L_TI,  L_T1};
         5'd13: u = '{OP_MUL,  L_C,    L_W,   L_T2};
         5'd14: u = '{OP_MUL,  L_T2,   L_TI,  L_T2};
         5'd15: u = '{OP_SUB,  L_T2,   L_ROLL, L_T2};
         5'd16: u = '{OP_MUL,  L_T1,   L_T2,  L_DL};
         5'd17: u = '{OP_MUL,  L_U,    L_TI,  L_T1};
         5'd18: u = '{OP_MUL,  L_T1,   L_TI,  L_T1};
         5'd19: u = '{OP_MUL,  L_S,    L_T1,  L_T1};
         5'd20: u = '{OP_ADD,  L_T1,   L_DN,  L_UN};
         5'd21: u = '{OP_MUL,  L_COT,  L_UN,  L_T1};
         5'd22: u = '{OP_ADD,  L_T1,   L_DL,  L_UL};
         5'd23: u = '{OP_MUL,  L_T,    L_CSC, L_T1};
         5'd24: u = '{OP_MUL,  L_T1,   L_YAW, L_T1};
         5'd25: u = '{OP_ADD,  L_BANK, L_T1,  L_T1};
         5'd26: u = '{OP_MULH, L_T,    L_UN,  L_T2};
         5'd27: u = '{OP_ADD,  L_T1,   L_T2,  L_BANK};
         5'd28: u = '{OP_MUL,  L_T,    L_UN,  L_T1};
         5'd29: u = '{OP_ADD,  L_YAW,  L_T1,  L_YAW};
         5'd30: u = '{OP_MUL,  L_T,    L_UL,  L_T1};
         5'd31: u = '{OP_ADD,  L_ROLL, L_T1,  L_ROLL};
         default: u = '{OP_ADD, L_T1, L_T2, L_T1};
      endcase
      return u;
   endfunction

endpackage

### hw/rtl/barg_cordic.sv
// ----------------------------------------------------------------------------
// barg_cordic: iterative sine and cosine
// Reduces the angle into [-pi, pi], folds it into [-pi/2, pi/2], then runs one
// rotation-mode CORDIC iteration per cycle through a single shift-add stage.
// ----------------------------------------------------------------------------
module barg_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [barg_pkg::ANG_W-1:0]    angle,
   output logic                                 done,
   output logic signed [barg_pkg::TRIG_W-1:0]   sin_val,
   output logic signed [barg_pkg::TRIG_W-1:0]   cos_val
);

   logic signed [barg_pkg::Z_W-1:0]  z_ff, z_in, z_load;
   logic signed [barg_pkg::XY_W-1:0] x_ff, x_in, y_ff, y_in, x_sh, y_sh, x_rnd, y_rnd;
   logic [barg_pkg::STEP_CNT_W-1:0]  step_ff, step_in;
   logic busy_ff, busy_in, fold_ff, fold_in, neg_ff, neg_in, done_ff, done_in;

   // The input range keeps the scaled angle within one turn of zero.
   always_comb begin
      z_load = barg_pkg::Z_W'(angle) <<< barg_pkg::TRIG_SHIFT;
      if (z_load > barg_pkg::Q30_PI) begin
         z_load = z_load - barg_pkg::Q30_TWO_PI;
      end else if (z_load < -barg_pkg::Q30_PI) begin
         z_load = z_load + barg_pkg::Q30_TWO_PI;
      end
   end

   assign x_sh = x_ff >>> step_ff;
   assign y_sh = y_ff >>> step_ff;

   always_comb begin
      z_in = z_ff;
      x_in = x_ff;
      y_in = y_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      fold_in = fold_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      if (start) begin
         z_in = z_load;
         x_in = barg_pkg::Q30_GAIN;
         y_in = '0;
         step_in = '0;
         busy_in = 1'b1;
         fold_in = 1'b1;
         neg_in = 1'b0;
      end else if (busy_ff && fold_ff) begin
         fold_in = 1'b0;
         if (z_ff > barg_pkg::Q30_HALF_PI) begin
            z_in = z_ff - barg_pkg::Q30_PI;
            neg_in = 1'b1;
         end else if (z_ff < -barg_pkg::Q30_HALF_PI) begin
            z_in = z_ff + barg_pkg::Q30_PI;
            neg_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!z_ff[barg_pkg::Z_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - barg_pkg::atan_q30(5'(step_ff));
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + barg_pkg::atan_q30(5'(step_ff));
         end
         step_in = step_ff + 1'b1;
         if (step_ff == barg_pkg::STEP_CNT_W'(barg_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fold_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fold_ff <= fold_in;
         done_ff <= done_in;
      end
      z_ff <= z_in;
      x_ff <= x_in;
      y_ff <= y_in;
      step_ff <= step_in;
      neg_ff <= neg_in;
   end

   // Round half up from Q30 down to the output fraction.
   assign x_rnd = (x_ff + (barg_pkg::XY_W'(1) <<< (barg_pkg::TRIG_SHIFT - 1)))
                  >>> barg_pkg::TRIG_SHIFT;
   assign y_rnd = (y_ff + (barg_pkg::XY_W'(1) <<< (barg_pkg::TRIG_SHIFT - 1)))
                  >>> barg_pkg::TRIG_SHIFT;

   assign done = done_ff;
   assign sin_val = neg_ff ? -y_rnd[barg_pkg::TRIG_W-1:0] : y_rnd[barg_pkg::TRIG_W-1:0];
   assign cos_val = neg_ff ? -x_rnd[barg_pkg::TRIG_W-1:0] : x_rnd[barg_pkg::TRIG_W-1:0];

endmodule

### hw/rtl/barg_div.sv
// ----------------------------------------------------------------------------
// barg_div: radix-2 restoring divider
// Truncating signed division, one quotient bit per cycle, with the quotient
// saturated to the 32-bit signed range.
// ----------------------------------------------------------------------------
module barg_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [barg_pkg::NUM_W-1:0]    numer,
   input  logic signed [barg_pkg::DEN_W-1:0]    denom,
   output logic                                 done,
   output logic signed [barg_pkg::WORD_W-1:0]   quot,
   output logic                                 sat
);

   localparam int CNT_W = $clog2(barg_pkg::NUM_W);

   logic [barg_pkg::NUM_W-1:0] q_ff, q_in;
   logic [barg_pkg::DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [barg_pkg::DEN_W:0]   rem_sh, diff;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [barg_pkg::NUM_W-1:0] lim;

   assign rem_sh = {rem_ff, q_ff[barg_pkg::NUM_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = numer[barg_pkg::NUM_W-1] ? barg_pkg::NUM_W'(-numer) : numer;
         den_in = denom[barg_pkg::DEN_W-1] ? barg_pkg::DEN_W'(-denom) : denom;
         rem_in = '0;
         cnt_in = CNT_W'(barg_pkg::NUM_W - 1);
         neg_in = numer[barg_pkg::NUM_W-1] ^ denom[barg_pkg::DEN_W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[barg_pkg::DEN_W]) begin
            rem_in = diff[barg_pkg::DEN_W-1:0];
            q_in = {q_ff[barg_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[barg_pkg::DEN_W-1:0];
            q_in = {q_ff[barg_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   // A negative quotient may reach one step further than a positive one.
   assign lim = neg_ff ? (barg_pkg::NUM_W'(1) << (barg_pkg::WORD_W - 1))
                       : ((barg_pkg::NUM_W'(1) << (barg_pkg::WORD_W - 1)) - 1'b1);

   always_comb begin
      sat = q_ff > lim;
      if (sat) begin
         quot = neg_ff ? barg_pkg::WORD_MIN : barg_pkg::WORD_MAX;
      end else begin
         quot = neg_ff ? -q_ff[barg_pkg::WORD_W-1:0] : q_ff[barg_pkg::WORD_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

### hw/rtl/barg_alu.sv
// ----------------------------------------------------------------------------
// barg_alu: shared saturating arithmetic unit
// Fixed-point multiply (floored), half multiply, add and subtract, each
// clamped to the 32-bit signed range with a saturation indication.
// ----------------------------------------------------------------------------
module barg_alu (
   input  barg_pkg::op_type                    op,
   input  logic signed [barg_pkg::WORD_W-1:0]  opa,
   input  logic signed [barg_pkg::WORD_W-1:0]  opb,
   output logic signed [barg_pkg::WORD_W-1:0]  result,
   output logic                                sat
);

   localparam int WIDE_W = 2 * barg_pkg::WORD_W;

   logic signed [WIDE_W-1:0] prod, wide;

   assign prod = WIDE_W'(opa) * WIDE_W'(opb);

   always_comb begin
      case (op)
         barg_pkg::OP_MUL:  wide = prod >>> barg_pkg::FRAC_BITS;
         barg_pkg::OP_MULH: wide = prod >>> (barg_pkg::FRAC_BITS + 1);
         barg_pkg::OP_ADD:  wide = WIDE_W'(opa) + WIDE_W'(opb);
         barg_pkg::OP_SUB:  wide = WIDE_W'(opa) - WIDE_W'(opb);
         default:           wide = '0;
      endcase
      if (wide > WIDE_W'(barg_pkg::WORD_MAX)) begin
         result = barg_pkg::WORD_MAX;
         sat = 1'b1;
      end else if (wide < WIDE_W'(barg_pkg::WORD_MIN)) begin
         result = barg_pkg::WORD_MIN;
         sat = 1'b1;
      end else begin
         result = wide[barg_pkg::WORD_W-1:0];
         sat = 1'b0;
      end
   end

endmodule

### hw/rtl/bank_attitude_reference_generator.sv
// ----------------------------------------------------------------------------
// bank_attitude_reference_generator: bank-angle attitude reference update
// A beat runs through the CORDIC, two divides for cotangent and cosecant (both
// skipped when the sine is zero), 32 micro-ops on the shared multiplier/adder
// and a hand-off state. One beat is in work at a time, so a new request is
// taken only once the previous one has been handed off. A stalled response
// holds the block until it leaves.
// Reset (synchronous, active high) clears the three references and sets the
// registers to their defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
module bank_attitude_reference_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  barg_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output barg_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [barg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [barg_pkg::WORD_W-1:0]         csr_write_data
);

   // Configuration registers.
   logic signed [barg_pkg::WORD_W-1:0] bank_gain_ff, rate_gain_ff;
   logic [barg_pkg::PERIOD_W-1:0]      period_ff;
   logic [barg_pkg::INVP_W-1:0]        inv_period_ff;
   logic signed [barg_pkg::POLE_W-1:0] roll_pole_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_gain_ff <= '0;
         rate_gain_ff <= '0;
         period_ff <= barg_pkg::PERIOD_RESET;
         inv_period_ff <= barg_pkg::INV_PER_RESET;
         roll_pole_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            barg_pkg::CSR_BANK_GAIN: bank_gain_ff <= csr_write_data;
            barg_pkg::CSR_RATE_GAIN: rate_gain_ff <= csr_write_data;
            barg_pkg::CSR_PERIOD:    period_ff <= csr_write_data[barg_pkg::PERIOD_W-1:0];
            barg_pkg::CSR_INV_PER:   inv_period_ff <= csr_write_data[barg_pkg::INVP_W-1:0];
            barg_pkg::CSR_ROLL_POLE: roll_pole_ff <= csr_write_data[barg_pkg::POLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   barg_pkg::state_type state_ff, state_in;
   logic [barg_pkg::PC_W-1:0] pc_ff, pc_in;
   logic req_accept, rsp_free;

   logic cordic_done, div_start, div_done, div_sat;
   logic signed [barg_pkg::TRIG_W-1:0] sin_val, cos_val;
   logic signed [barg_pkg::NUM_W-1:0]  div_numer;
   logic signed [barg_pkg::DEN_W-1:0]  div_denom;
   logic signed [barg_pkg::WORD_W-1:0] div_quot;

   assign req_stall  = state_ff != barg_pkg::ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         barg_pkg::ST_IDLE:
            if (req_accept) state_in = barg_pkg::ST_TRIG;
         barg_pkg::ST_TRIG:
            if (cordic_done) begin
               state_in = (sin_val == '0) ? barg_pkg::ST_CALC : barg_pkg::ST_DIV_COT;
            end
         barg_pkg::ST_DIV_COT:
            if (div_done) state_in = barg_pkg::ST_DIV_CSC;
         barg_pkg::ST_DIV_CSC:
            if (div_done) state_in = barg_pkg::ST_CALC;
         barg_pkg::ST_CALC:
            if (pc_ff == barg_pkg::PC_W'(barg_pkg::UOP_COUNT - 1)) begin
               state_in = barg_pkg::ST_FINISH;
            end
         barg_pkg::ST_FINISH:
            if (rsp_free) state_in = barg_pkg::ST_IDLE;
         default: state_in = barg_pkg::ST_IDLE;
      endcase
   end

   // The first divide takes the CORDIC result as it appears; the second one
   // works from the latched sine.
   logic signed [barg_pkg::TRIG_W-1:0] s_ff, c_ff;

   always_comb begin
      div_start = 1'b0;
      div_numer = barg_pkg::NUM_W'(cos_val) <<< barg_pkg::FRAC_BITS;
      div_denom = sin_val;
      case (state_ff)
         barg_pkg::ST_TRIG:
            div_start = cordic_done && (sin_val != '0);
         barg_pkg::ST_DIV_COT: begin
            div_start = div_done;
            div_numer = barg_pkg::NUM_W'(1) <<< (2 * barg_pkg::FRAC_BITS);
            div_denom = s_ff;
         end
         default: ;
      endcase
   end

   barg_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept),
      .angle   (req_payload.angle_of_attack),
      .done    (cordic_done),
      .sin_val (sin_val),
      .cos_val (cos_val)
   );

   barg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot),
      .sat   (div_sat)
   );

   // Working registers of one beat.
   logic signed [barg_pkg::WORD_W-1:0] mt_ff, w_ff, u_ff;
   logic signed [barg_pkg::WORD_W-1:0] cot_ff, cot_in, csc_ff, csc_in;
   logic signed [barg_pkg::WORD_W-1:0] bank_ff, bank_in, yaw_ff, yaw_in, roll_ff, roll_in;
   logic signed [barg_pkg::WORD_W-1:0] kmu_ff, kmu_in, kw_ff, kw_in, t1_ff, t1_in;
   logic signed [barg_pkg::WORD_W-1:0] t2_ff, t2_in, dn_ff, dn_in, dl_ff, dl_in;
   logic signed [barg_pkg::WORD_W-1:0] un_ff, un_in, ul_ff, ul_in;
   logic fault_ff, fault_in;

   barg_pkg::uop_type uop;
   logic signed [barg_pkg::WORD_W-1:0] opa, opb, alu_result;
   logic alu_sat;

   assign uop = barg_pkg::uop_at(pc_ff);

   function automatic logic signed [barg_pkg::WORD_W-1:0] read_loc(
      input barg_pkg::loc_type loc,
      input logic signed [barg_pkg::WORD_W-1:0] c0, c1, mt, w, u,
      input logic [barg_pkg::PERIOD_W-1:0] t,
      input logic [barg_pkg::INVP_W-1:0] ti,
      input logic signed [barg_pkg::POLE_W-1:0] p,
      input logic signed [barg_pkg::TRIG_W-1:0] s, c,
      input logic signed [barg_pkg::WORD_W-1:0] bank, yaw, roll, cot, csc,
      input logic signed [barg_pkg::WORD_W-1:0] kmu, kw, t1, t2, dn, dl, un, ul);
      logic signed [barg_pkg::WORD_W-1:0] v;
      case (loc)
         barg_pkg::L_C0:   v = c0;
         barg_pkg::L_C1:   v = c1;
         barg_pkg::L_T:    v = barg_pkg::WORD_W'(t);
         barg_pkg::L_TI:   v = barg_pkg::WORD_W'(ti);
         barg_pkg::L_ONE:  v = barg_pkg::ONE_Q;
         barg_pkg::L_P:    v = barg_pkg::WORD_W'(p);
         barg_pkg::L_S:    v = barg_pkg::WORD_W'(s);
         barg_pkg::L_C:    v = barg_pkg::WORD_W'(c);
         barg_pkg::L_W:    v = w;
         barg_pkg::L_MT:   v = mt;
         barg_pkg::L_U:    v = u;
         barg_pkg::L_BANK: v = bank;
         barg_pkg::L_YAW:  v = yaw;
         barg_pkg::L_ROLL: v = roll;
         barg_pkg::L_COT:  v = cot;
         barg_pkg::L_CSC:  v = csc;
         barg_pkg::L_KMU:  v = kmu;
         barg_pkg::L_KW:   v = kw;
         barg_pkg::L_T1:   v = t1;
         barg_pkg::L_T2:   v = t2;
         barg_pkg::L_DN:   v = dn;
         barg_pkg::L_DL:   v = dl;
         barg_pkg::L_UN:   v = un;
         barg_pkg::L_UL:   v = ul;
         default:          v = '0;
      endcase
      return v;
   endfunction

   assign opa = read_loc(uop.src_a, bank_gain_ff, rate_gain_ff, mt_ff, w_ff, u_ff,
                         period_ff, inv_period_ff, roll_pole_ff, s_ff, c_ff,
                         bank_ff, yaw_ff, roll_ff, cot_ff, csc_ff,
                         kmu_ff, kw_ff, t1_ff, t2_ff, dn_ff, dl_ff, un_ff, ul_ff);
   assign opb = read_loc(uop.src_b, bank_gain_ff, rate_gain_ff, mt_ff, w_ff, u_ff,
                         period_ff, inv_period_ff, roll_pole_ff, s_ff, c_ff,
                         bank_ff, yaw_ff, roll_ff, cot_ff, csc_ff,
                         kmu_ff, kw_ff, t1_ff, t2_ff, dn_ff, dl_ff, un_ff, ul_ff);

   barg_alu u_alu (
      .op     (uop.op),
      .opa    (opa),
      .opb    (opb),
      .result (alu_result),
      .sat    (alu_sat)
   );

   // Register updates: divider results, then one micro-op result per cycle.
   always_comb begin
      pc_in = pc_ff;
      fault_in = fault_ff;
      cot_in = cot_ff;
      csc_in = csc_ff;
      bank_in = bank_ff;
      yaw_in = yaw_ff;
      roll_in = roll_ff;
      kmu_in = kmu_ff;
      kw_in = kw_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      dn_in = dn_ff;
      dl_in = dl_ff;
      un_in = un_ff;
      ul_in = ul_ff;
      case (state_ff)
         barg_pkg::ST_IDLE: begin
            fault_in = 1'b0;
            pc_in = '0;
         end
         barg_pkg::ST_TRIG:
            if (cordic_done && (sin_val == '0)) begin
               // A zero sine leaves cotangent and cosecant at zero.
               fault_in = 1'b1;
               cot_in = '0;
               csc_in = '0;
            end
         barg_pkg::ST_DIV_COT:
            if (div_done) begin
               cot_in = div_quot;
               fault_in = fault_ff | div_sat;
            end
         barg_pkg::ST_DIV_CSC:
            if (div_done) begin
               csc_in = div_quot;
               fault_in = fault_ff | div_sat;
            end
         barg_pkg::ST_CALC: begin
            pc_in = pc_ff + 1'b1;
            fault_in = fault_ff | alu_sat;
            case (uop.dst)
               barg_pkg::L_BANK: bank_in = alu_result;
               barg_pkg::L_YAW:  yaw_in = alu_result;
               barg_pkg::L_ROLL: roll_in = alu_result;
               barg_pkg::L_KMU:  kmu_in = alu_result;
               barg_pkg::L_KW:   kw_in = alu_result;
               barg_pkg::L_T1:   t1_in = alu_result;
               barg_pkg::L_T2:   t2_in = alu_result;
               barg_pkg::L_DN:   dn_in = alu_result;
               barg_pkg::L_DL:   dl_in = alu_result;
               barg_pkg::L_UN:   un_in = alu_result;
               barg_pkg::L_UL:   ul_in = alu_result;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   logic rsp_valid_ff, rsp_valid_in;
   barg_pkg::rsp_type rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == barg_pkg::ST_FINISH && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= barg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bank_ff <= '0;
         yaw_ff <= '0;
         roll_ff <= '0;
         pc_ff <= '0;
         fault_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bank_ff <= bank_in;
         yaw_ff <= yaw_in;
         roll_ff <= roll_in;
         pc_ff <= pc_in;
         fault_ff <= fault_in;
      end
      if (req_accept) begin
         mt_ff <= req_payload.bank_target;
         w_ff <= req_payload.bank_rate_target;
         u_ff <= req_payload.bank_feedforward;
      end
      if (state_ff == barg_pkg::ST_TRIG && cordic_done) begin
         s_ff <= sin_val;
         c_ff <= cos_val;
      end
      if (state_ff == barg_pkg::ST_FINISH && rsp_free) begin
         rsp_ff.roll_command <= ul_ff;
         rsp_ff.yaw_command <= un_ff;
         rsp_ff.bank_ref_next <= bank_ff;
         rsp_ff.yaw_rate_ref_next <= yaw_ff;
         rsp_ff.roll_rate_ref_next <= roll_ff;
         rsp_ff.fault_flag <= fault_ff;
      end
      cot_ff <= cot_in;
      csc_ff <= csc_in;
      kmu_ff <= kmu_in;
      kw_ff <= kw_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      dn_ff <= dn_in;
      dl_ff <= dl_in;
      un_ff <= un_in;
      ul_ff <= ul_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### dv/tb_bank_attitude_reference_generator.sv
// ----------------------------------------------------------------------------
// tb_bank_attitude_reference_generator: self-checking bench for the bank
// attitude reference generator
// A table of probe beats and then about twelve hundred random beats run under
// several register settings. The extremes are among them. Each accepted request
// is fed through a bit-exact fixed-point predictor that lives in this bench.
// Every response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bank_attitude_reference_generator;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CYCLE_LIMIT   = 1000000;
   localparam int     TAIL_CYCLES   = 300;
   localparam int     IDLE_CYCLES   = 130;
   localparam int     HOLD_CYCLES   = 1500;
   localparam int     PHASE_BEATS   = 150;
   localparam int     PHASE_COUNT   = 8;
   localparam int     PROBE_COUNT   = 16;
   // Index 7 is past the register list, so a write to it must change nothing.
   localparam logic [barg_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint UNIT        = 64'sd1 <<< barg_pkg::FRAC_BITS;
   localparam longint INT32_HI    = 64'sd2147483647;
   localparam longint INT32_LO    = -64'sd2147483648;

   localparam longint ARCTAN_Q30 [16] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767
   };

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   barg_pkg::req_type              req_payload;
   logic                           rsp_valid;
   logic                           rsp_stall;
   barg_pkg::rsp_type              rsp_payload;
   logic                           csr_write_enable;
   logic [barg_pkg::CSR_IDX_W-1:0] csr_index;
   logic [barg_pkg::WORD_W-1:0]    csr_write_data;

   bank_attitude_reference_generator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the registers and of the three reference states.
   longint bank_gain, rate_gain, period_q, inv_period_q, pole_q;
   longint bank_state, yaw_state, roll_state;
   bit     clamp_hit;

   barg_pkg::rsp_type pending_updates[$];
   int      fail_count;
   bit      no_idle;        // Both sides run back to back while this is set.
   bit      hold_off_now;   // Asks the receiver for one long stall.
   bit      first_is_known; // The next predicted beat has a hand-written answer.

   // The probe beats. The first one, right after reset with every target zero
   // and the angle near a right angle, must leave every output at zero.
   barg_pkg::req_type probe_table [PROBE_COUNT] = '{
      '{19'sd102944, 32'sd0, 32'sd0, 32'sd0},
      '{19'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{19'sd1, 32'sd65536, 32'sd65536, 32'sd65536},
      '{-19'sd1, -32'sd65536, -32'sd65536, -32'sd65536},
      '{19'sd262143, 32'sd2147483647, 32'sd2147483647, 32'sd2147483647},
      '{-19'sd262144, -32'sd2147483648, -32'sd2147483648, -32'sd2147483648},
      '{19'sd205887, 32'sd131072, -32'sd65536, 32'sd32768},
      '{-19'sd205887, -32'sd131072, 32'sd65536, -32'sd32768},
      '{-19'sd102944, 32'sd2147483647, -32'sd2147483648, 32'sd0},
      '{19'sd51472, -32'sd2147483648, 32'sd2147483647, -32'sd1},
      '{19'sd102943, 32'sd0, 32'sd0, 32'sd2147483647},
      '{19'sd102945, 32'sd0, 32'sd0, -32'sd2147483648},
      '{-19'sd1, -32'sd1, -32'sd1, -32'sd1},
      '{19'sd131072, 32'sd1, 32'sd1, 32'sd1},
      '{19'sd8, 32'sd65536, 32'sd0, 32'sd0},
      '{-19'sd205888, 32'sd6553600, 32'sd655360, -32'sd655360}
   };

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp32(input longint v);
      if (v > INT32_HI) begin
         clamp_hit = 1'b1;
         return INT32_HI;
      end
      if (v < INT32_LO) begin
         clamp_hit = 1'b1;
         return INT32_LO;
      end
      return v;
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      return clamp32((a * b) >>> barg_pkg::FRAC_BITS);
   endfunction

   function automatic longint fx_mul_half(input longint a, input longint b);
      return clamp32((a * b) >>> (barg_pkg::FRAC_BITS + 1));
   endfunction

   function automatic longint fx_add(input longint a, input longint b);
      return clamp32(a + b);
   endfunction

   function automatic longint fx_sub(input longint a, input longint b);
      return clamp32(a - b);
   endfunction

   // Rotation-mode CORDIC in Q30, after the angle is wrapped into [-pi, pi]
   // and folded into [-pi/2, pi/2].
   function automatic void sine_cosine(input longint angle, output longint s,
                                       output longint c);
      longint z, x, y, nx;
      bit     folded;
      z = (angle <<< (30 - barg_pkg::FRAC_BITS)) % TWO_PI_Q30;
      x = GAIN_Q30;
      y = 0;
      folded = 1'b0;
      if (z > PI_Q30) z -= TWO_PI_Q30;
      if (z < -PI_Q30) z += TWO_PI_Q30;
      if (z > HALF_PI_Q30) begin
         z -= PI_Q30;
         folded = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z += PI_Q30;
         folded = 1'b1;
      end
      for (int i = 0; i < barg_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= ARCTAN_Q30[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ARCTAN_Q30[i];
         end
         x = nx;
      end
      x = (x + (64'sd1 <<< (29 - barg_pkg::FRAC_BITS))) >>> (30 - barg_pkg::FRAC_BITS);
      y = (y + (64'sd1 <<< (29 - barg_pkg::FRAC_BITS))) >>> (30 - barg_pkg::FRAC_BITS);
      s = folded ? -y : y;
      c = folded ? -x : x;
   endfunction

   // One reference update: commands, new references and the fault flag.
   function automatic barg_pkg::rsp_type predict_bank_update(input barg_pkg::req_type r);
      longint  mt, w, u, s, c, cot, csc, kmu, kw, dn, dl, un, ul, bn, yn, rn;
      barg_pkg::rsp_type p;
      mt = longint'(r.bank_target);
      w  = longint'(r.bank_rate_target);
      u  = longint'(r.bank_feedforward);
      clamp_hit = 1'b0;
      sine_cosine(longint'(r.angle_of_attack), s, c);
      if (s == 0) begin
         // A zero sine has no cotangent or cosecant; both are taken as zero.
         clamp_hit = 1'b1;
         cot = 0;
         csc = 0;
      end else begin
         cot = clamp32((c * UNIT) / s);
         csc = clamp32((UNIT * UNIT) / s);
      end
      kmu = fx_mul(fx_mul(fx_mul(bank_gain, s), inv_period_q), inv_period_q);
      kw  = fx_mul(rate_gain, inv_period_q);
      dn  = fx_add(fx_mul(kw, fx_sub(fx_mul(fx_mul(s, w), inv_period_q), yaw_state)),
                   fx_mul(kmu, fx_sub(mt, bank_state)));
      dl  = fx_mul(fx_mul(fx_sub(UNIT, pole_q), inv_period_q),
                   fx_sub(fx_mul(fx_mul(c, w), inv_period_q), roll_state));
      un  = fx_add(fx_mul(s, fx_mul(fx_mul(u, inv_period_q), inv_period_q)), dn);
      ul  = fx_add(fx_mul(cot, un), dl);
      bn  = fx_add(fx_add(bank_state, fx_mul(fx_mul(period_q, csc), yaw_state)),
                   fx_mul_half(period_q, un));
      yn  = fx_add(yaw_state, fx_mul(period_q, un));
      rn  = fx_add(roll_state, fx_mul(period_q, ul));
      bank_state = bn;
      yaw_state  = yn;
      roll_state = rn;
      p.roll_command       = ul[31:0];
      p.yaw_command        = un[31:0];
      p.bank_ref_next      = bn[31:0];
      p.yaw_rate_ref_next  = yn[31:0];
      p.roll_rate_ref_next = rn[31:0];
      p.fault_flag         = clamp_hit;
      return p;
   endfunction

   // ------------------------------------------------------------- clock, limit

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous ceiling: the worst-case time per beat, plus the long receiver hold,
   // plus the idle waits between phases, taken several times.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------ monitor

   task automatic check_field(input string name, input longint want,
                              input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name,
                  want, got);
         fail_count++;
      end
   endtask

   // Requests are predicted the moment they are accepted, so the shadow state
   // advances in exactly the order the block sees the beats.
   always @(posedge clock) begin
      barg_pkg::rsp_type want;
      barg_pkg::rsp_type known;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            known = predict_bank_update(req_payload);
            if (first_is_known) begin
               known = '0;
               first_is_known = 1'b0;
            end
            pending_updates.push_back(known);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_updates.size() == 0) begin
               $display("%0t: response beat with nothing expected, expected none, actual %h",
                        $realtime, rsp_payload);
               fail_count++;
            end else begin
               want = pending_updates.pop_front();
               check_field("roll_command", want.roll_command,
                           rsp_payload.roll_command);
               check_field("yaw_command", want.yaw_command, rsp_payload.yaw_command);
               check_field("bank_ref_next", want.bank_ref_next,
                           rsp_payload.bank_ref_next);
               check_field("yaw_rate_ref_next", want.yaw_rate_ref_next,
                           rsp_payload.yaw_rate_ref_next);
               check_field("roll_rate_ref_next", want.roll_rate_ref_next,
                           rsp_payload.roll_rate_ref_next);
               check_field("fault_flag", want.fault_flag, rsp_payload.fault_flag);
            end
         end
      end
   end

   // ----------------------------------------------------------------- receiver

   // The receiver draws a random stall before every response beat. When asked,
   // it instead holds off for a long stretch. The block then fills up and pushes
   // back on the request side.
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_now) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_now = 1'b0;
         end
         n = no_idle ? 0 : $urandom_range(0, 8);
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------- sender

   // Called at a falling edge. It returns at the falling edge after the beat
   // was taken, with valid still high. The next beat can then follow at once.
   task automatic send_beat(input barg_pkg::req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drops valid and waits until every predicted response has come back. It
   // then allows one full update time for the block to settle.
   task automatic drain_responses();
      req_valid = 1'b0;
      while (pending_updates.size() != 0) @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [barg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [barg_pkg::WORD_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         barg_pkg::CSR_BANK_GAIN: bank_gain    = longint'($signed(data));
         barg_pkg::CSR_RATE_GAIN: rate_gain    = longint'($signed(data));
         barg_pkg::CSR_PERIOD:    period_q     = longint'(data[barg_pkg::PERIOD_W-1:0]);
         barg_pkg::CSR_INV_PER:   inv_period_q = longint'(data[barg_pkg::INVP_W-1:0]);
         barg_pkg::CSR_ROLL_POLE: pole_q = longint'($signed(data[barg_pkg::POLE_W-1:0]));
         default: ;
      endcase
   endtask

   // A signed value whose magnitude stays below 2^bits.
   function automatic logic [31:0] near_zero(input int bits);
      logic [31:0] v;
      v = $urandom_range(0, (1 << bits) - 1);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   // Register set per phase. Phases 2 and 3 pin the extremes. The rest use a
   // plausible period with its reciprocal, moderate gains and a stable pole.
   // The spare upper bits stay random to exercise the width masking.
   task automatic configure_phase(input int ph);
      logic [31:0] t;
      case (ph)
         2: begin
            write_csr(barg_pkg::CSR_BANK_GAIN, 32'h7FFF_FFFF);
            write_csr(barg_pkg::CSR_RATE_GAIN, 32'h8000_0000);
            write_csr(barg_pkg::CSR_PERIOD, 32'hFFFF_FFFF);
            write_csr(barg_pkg::CSR_INV_PER, 32'h7FFF_FFFF);
            write_csr(barg_pkg::CSR_ROLL_POLE, 32'h0001_FFFF);
            write_csr(CSR_UNMAPPED, $urandom());
         end
         3: begin
            write_csr(barg_pkg::CSR_BANK_GAIN, 32'h8000_0000);
            write_csr(barg_pkg::CSR_RATE_GAIN, 32'h7FFF_FFFF);
            write_csr(barg_pkg::CSR_PERIOD, 32'hFFF0_0000);
            write_csr(barg_pkg::CSR_INV_PER, 32'h8000_0000);
            write_csr(barg_pkg::CSR_ROLL_POLE, 32'hFFFE_0000);
         end
         default: begin
            t = $urandom_range(3277, 655360);
            write_csr(barg_pkg::CSR_BANK_GAIN, near_zero(20));
            write_csr(barg_pkg::CSR_RATE_GAIN, near_zero(19));
            write_csr(barg_pkg::CSR_PERIOD, {12'($urandom_range(0, 4095)), t[19:0]});
            write_csr(barg_pkg::CSR_INV_PER,
                      {1'($urandom_range(0, 1)), 31'((64'd1 << 32) / t)});
            write_csr(barg_pkg::CSR_ROLL_POLE, {14'($urandom()), 18'(near_zero(16))});
         end
      endcase
   endtask

   // Most beats are in the working envelope, with small angles and small
   // targets, so the references move without pinning at the rails. One beat
   // in four is raw random bits over every field.
   function automatic barg_pkg::req_type random_beat();
      barg_pkg::req_type r;
      if ($urandom_range(0, 3) == 0) begin
         r.angle_of_attack  = 19'($urandom());
         r.bank_target      = $urandom();
         r.bank_rate_target = $urandom();
         r.bank_feedforward = $urandom();
      end else begin
         r.angle_of_attack  = 19'(near_zero(17));
         r.bank_target      = near_zero(18);
         r.bank_rate_target = near_zero(17);
         r.bank_feedforward = near_zero(16);
      end
      return r;
   endfunction

   initial begin
      fail_count       = 0;
      no_idle          = 1'b0;
      hold_off_now     = 1'b0;
      first_is_known   = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = barg_pkg::CSR_BANK_GAIN;
      csr_write_data   = '0;
      bank_gain        = 0;
      rate_gain        = 0;
      period_q         = UNIT;
      inv_period_q     = UNIT;
      pole_q           = 0;
      bank_state       = 0;
      yaw_state        = 0;
      roll_state       = 0;
      reset            = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // The probe table runs first under the reset registers, then again
      // under the saturating extremes.
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) configure_phase(2);
         foreach (probe_table[k]) send_beat(probe_table[k]);
         drain_responses();
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         configure_phase(ph);
         no_idle = (ph == 5);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            // Phase 4 stalls the receiver for a long stretch mid-phase.
            // Phase 6 instead lets the sender wait until every response is back.
            if (ph == 4 && k == PHASE_BEATS / 2) hold_off_now = 1'b1;
            if (ph == 6 && k == PHASE_BEATS / 2) drain_responses();
            send_beat(random_beat());
         end
         drain_responses();
      end
      no_idle = 1'b0;

      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_updates.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
